// File: rtl/core/lpht_pkg.sv
// shared constants, types and codes of the linear-probe hash table
package lpht_pkg;

  // table geometry
  localparam int unsigned TABLE_SLOTS = 256;
  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int unsigned CNT_W       = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned ENTRY_W     = 32 + VALUE_BITS;
  // a new key is refused once this many slots are occupied
  localparam int unsigned LOAD_MAX    = (3 * TABLE_SLOTS) / 4;
  localparam bit          SLOTS_POW2  = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;

  // fixed field widths of the stream beats
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ENT_W  = 9;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_RFIND  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STS_NEW     = 3'd0,
    STS_UPDATED = 3'd1,
    STS_HIT     = 3'd2,
    STS_MISS    = 3'd3,
    STS_FULL    = 3'd4,
    STS_BADKEY  = 3'd5
  } status_e;

  // one result as handed from the engine to the output register
  typedef struct packed {
    status_e            status;
    logic [DATA_W-1:0]  found_value;
    logic [KEY_W-1:0]   found_key;
    logic [ENT_W-1:0]   entries_used;
  } res_t;

endpackage

// File: rtl/core/lpht_ram.sv
// generic simple dual-port ram, one write and one registered read port
module lpht_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/core/lpht_engine.sv
// probe sequencer: home slot, slot-per-cycle probe and scan, update of the table
module lpht_engine import lpht_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  op_e               op_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic [DATA_W-1:0] value_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output res_t              res_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_HOME  = 4'b0010,
    S_PROBE = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  op_e                    op_q, op_d;
  logic [KEY_W-1:0]       key_q, key_d;
  logic [VALUE_BITS-1:0]  val_q, val_d;
  logic [KEY_W-1:0]       key_sh_q, key_sh_d;
  logic [SLOT_W:0]        rem_q, rem_d;
  logic [2:0]             dig_q, dig_d;
  logic [SLOT_W-1:0]      iaddr_q, iaddr_d;
  logic [CNT_W-1:0]       icnt_q, icnt_d;
  logic                   chk_v_q, chk_v_d;
  logic                   chk_last_q, chk_last_d;
  logic [SLOT_W-1:0]      chk_addr_q, chk_addr_d;
  logic [CNT_W-1:0]       used_q, used_d;
  logic [TABLE_SLOTS-1:0] valid_q, valid_d;
  res_t                   res_q, res_d;

  logic                   accept;
  logic                   issue;
  logic                   we;
  logic [ENTRY_W-1:0]     wdata;
  logic [ENTRY_W-1:0]     rdata;
  logic [KEY_W-1:0]       rd_key;
  logic [VALUE_BITS-1:0]  rd_val;
  logic                   chk_vld;
  logic                   key_hit;
  logic                   rv_hit;
  logic                   stop;
  logic                   none;
  logic [SLOT_W:0]        rem_nx;
  logic [SLOT_W-1:0]      iaddr_nx;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  // slot memory, key in the low bits and value above it
  lpht_ram #(
    .DEPTH (TABLE_SLOTS),
    .WIDTH (ENTRY_W)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (chk_addr_q),
    .wdata_i (wdata),
    .re_i    (issue),
    .raddr_i (iaddr_q),
    .rdata_o (rdata)
  );

  assign wdata  = {val_q, key_q};
  assign rd_key = rdata[KEY_W-1:0];
  assign rd_val = rdata[ENTRY_W-1:KEY_W];

  // the slot being checked; occupancy comes from the valid bits
  assign chk_vld = valid_q[chk_addr_q];
  assign key_hit = chk_vld && (rd_key == key_q);
  assign rv_hit  = chk_vld && (rd_val == val_q);
  assign stop    = chk_v_q && ((op_q == OP_RFIND) ? rv_hit : (key_hit || !chk_vld));
  assign none    = chk_v_q && !stop && chk_last_q;

  // keep issuing reads until every slot has been read once
  assign issue    = (state_q == S_PROBE) && (icnt_q != CNT_W'(TABLE_SLOTS));
  assign iaddr_nx = (iaddr_q == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : iaddr_q + 1'b1;

  // four key bits per cycle into the remainder by the slot count
  always_comb begin
    rem_nx = rem_q;
    for (int j = 0; j < 4; j++) begin
      rem_nx = {rem_nx[SLOT_W-1:0], key_sh_q[KEY_W-1-j]};
      if (rem_nx >= (SLOT_W + 1)'(TABLE_SLOTS)) begin
        rem_nx = rem_nx - (SLOT_W + 1)'(TABLE_SLOTS);
      end
    end
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    key_d      = key_q;
    val_d      = val_q;
    key_sh_d   = key_sh_q;
    rem_d      = rem_q;
    dig_d      = dig_q;
    iaddr_d    = iaddr_q;
    icnt_d     = icnt_q;
    chk_v_d    = 1'b0;
    chk_last_d = chk_last_q;
    chk_addr_d = chk_addr_q;
    used_d     = used_q;
    valid_d    = valid_q;
    res_d      = res_q;
    we         = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d              = op_i;
          key_d             = key_i;
          val_d             = VALUE_BITS'(value_i);
          key_sh_d          = key_i;
          rem_d             = '0;
          dig_d             = '0;
          icnt_d            = '0;
          res_d.status      = STS_MISS;
          res_d.found_value = '0;
          res_d.found_key   = '0;
          res_d.entries_used = ENT_W'(used_q);
          case (op_i)
            OP_CLEAR: begin
              valid_d            = '0;
              used_d             = '0;
              res_d.status       = STS_NEW;
              res_d.entries_used = '0;
              state_d            = S_DONE;
            end
            OP_INSERT: begin
              if (key_i == '0) begin
                res_d.status = STS_BADKEY;
                state_d      = S_DONE;
              end else if (SLOTS_POW2) begin
                iaddr_d = key_i[SLOT_W-1:0];
                state_d = S_PROBE;
              end else begin
                state_d = S_HOME;
              end
            end
            OP_LOOKUP: begin
              if (key_i == '0 || used_q == '0) begin
                state_d = S_DONE;
              end else if (SLOTS_POW2) begin
                iaddr_d = key_i[SLOT_W-1:0];
                state_d = S_PROBE;
              end else begin
                state_d = S_HOME;
              end
            end
            OP_RFIND: begin
              iaddr_d = '0;
              state_d = S_PROBE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_HOME: begin
        rem_d    = rem_nx;
        key_sh_d = key_sh_q << 4;
        dig_d    = dig_q + 1'b1;
        if (dig_q == 3'd7) begin
          iaddr_d = rem_nx[SLOT_W-1:0];
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (issue) begin
          iaddr_d    = iaddr_nx;
          icnt_d     = icnt_q + 1'b1;
          chk_v_d    = 1'b1;
          chk_addr_d = iaddr_q;
          chk_last_d = (icnt_q == CNT_W'(TABLE_SLOTS - 1));
        end
        if (stop || none) begin
          chk_v_d = 1'b0;
          state_d = S_DONE;
          case (op_q)
            OP_INSERT: begin
              if (none) begin
                res_d.status = STS_FULL;
              end else if (key_hit) begin
                we           = 1'b1;
                res_d.status = STS_UPDATED;
              end else if (used_q >= CNT_W'(LOAD_MAX)) begin
                res_d.status = STS_FULL;
              end else begin
                we                   = 1'b1;
                valid_d[chk_addr_q]  = 1'b1;
                used_d               = used_q + 1'b1;
                res_d.status         = STS_NEW;
                res_d.entries_used   = ENT_W'(used_q + 1'b1);
              end
            end
            OP_LOOKUP: begin
              if (stop && key_hit) begin
                res_d.status      = STS_HIT;
                res_d.found_value = DATA_W'(rd_val);
              end
            end
            OP_RFIND: begin
              if (stop) begin
                res_d.status    = STS_HIT;
                res_d.found_key = rd_key;
              end
            end
            default: begin
              res_d.status = STS_MISS;
            end
          endcase
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      chk_v_q <= 1'b0;
      used_q  <= '0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      chk_v_q <= chk_v_d;
      used_q  <= used_d;
      valid_q <= valid_d;
    end
  end

  // working registers of the current item
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    val_q      <= val_d;
    key_sh_q   <= key_sh_d;
    rem_q      <= rem_d;
    dig_q      <= dig_d;
    iaddr_q    <= iaddr_d;
    icnt_q     <= icnt_d;
    chk_last_q <= chk_last_d;
    chk_addr_q <= chk_addr_d;
    res_q      <= res_d;
  end

  // occupied slot count matches the valid bits
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(used_q))
    else $error("used count differs from occupied slots");

  // load limit is never passed
  a_load_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(LOAD_MAX))
    else $error("occupancy above load limit");

  // the table is written only when a probe ends
  a_write_at_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == S_PROBE) && (op_q == OP_INSERT) && stop)
    else $error("slot write outside a finished insert probe");

  // a clear empties the table at once
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i == OP_CLEAR) |=> (used_q == '0) && (valid_q == '0))
    else $error("clear left occupied slots");

endmodule

// File: rtl/core/linear_probe_hash_table.sv
// Linear-probe hash table: 256 slots of 32-bit key and value; key zero is never stored.
// One operation per input beat, one result beat for each. Slots live in a single
// simple dual-port memory read one slot per cycle; occupancy is held in one valid bit
// per slot, so a clear takes effect at once and no clearing pass follows reset.
// Insert and lookup probe from the home slot onward, one slot per step, after reducing
// the key by the slot count when that count is not a power of two; reverse search
// scans from slot 0 up to the matching slot, or through all 256 when nothing matches;
// clear, bad key and an early miss go to the result without a probe.
// A finished result waits in the output register while the next beat is taken;
// the engine is ready again as soon as its result moves there.
module linear_probe_hash_table import lpht_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // key [31:0], value [63:32]
  input  logic [1:0]  s_axis_tuser,   // opcode [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata    // status [2:0], found_value [34:3],
                                      // found_key [66:35], entries_used [75:67], zero above
);

  logic res_valid;
  logic res_take;
  res_t res;
  logic out_v_q;
  res_t out_q;

  lpht_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (op_e'(s_axis_tuser)),
    .key_i       (s_axis_tdata[31:0]),
    .value_i     (s_axis_tdata[63:32]),
    .res_valid_o (res_valid),
    .res_ready_i (res_take),
    .res_o       (res)
  );

  // output register takes a result when empty or being drained
  assign res_take = !out_v_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (res_take) begin
      out_v_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take && res_valid) begin
      out_q <= res;
    end
  end

  // result beat packing
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {4'b0000, out_q.entries_used, out_q.found_key,
                          out_q.found_value, out_q.status};

endmodule

// File: test/linear_probe_hash_table_checker.sv
// checker for the linear-probe hash table: mirrors the table and compares result beats
`timescale 1ns / 100ps

module linear_probe_hash_table_checker import lpht_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // key [31:0], value [63:32]
  input  logic [1:0]  s_axis_tuser,   // opcode [1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [79:0] m_axis_tdata,   // status [2:0], found_value [34:3],
                                      // found_key [66:35], entries_used [75:67], zero above
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);

  // mirrored table contents
  logic [KEY_W-1:0]      slot_key [TABLE_SLOTS];
  logic [VALUE_BITS-1:0] slot_val [TABLE_SLOTS];
  int unsigned           occupied;
  res_t                  expected_results [$];
  int unsigned           mismatches;

  // slot holding the key, or first empty slot on its path, or -1
  function automatic int probe_for(logic [KEY_W-1:0] key);
    int idx;
    idx = int'(key % TABLE_SLOTS);
    for (int n = 0; n < TABLE_SLOTS; n++) begin
      if (slot_key[idx] == key || slot_key[idx] == '0) return idx;
      idx = (idx + 1) % TABLE_SLOTS;
    end
    return -1;
  endfunction

  // apply one operation to the mirror and return the result it yields
  function automatic res_t apply_op(op_e op, logic [KEY_W-1:0] key,
                                    logic [VALUE_BITS-1:0] val);
    res_t r;
    int   s;
    r = '0;
    r.status = STS_MISS;
    case (op)
      OP_INSERT: begin
        if (key == '0) begin
          r.status = STS_BADKEY;
        end else begin
          s = probe_for(key);
          if (s < 0) begin
            r.status = STS_FULL;
          end else if (slot_key[s] == key) begin
            slot_val[s] = val;
            r.status = STS_UPDATED;
          end else if (4 * (occupied + 1) > 3 * TABLE_SLOTS) begin
            r.status = STS_FULL;
          end else begin
            slot_key[s] = key;
            slot_val[s] = val;
            occupied++;
            r.status = STS_NEW;
          end
        end
      end
      OP_LOOKUP: begin
        if (key != '0 && occupied != 0) begin
          s = probe_for(key);
          if (s >= 0 && slot_key[s] == key) begin
            r.status = STS_HIT;
            r.found_value = slot_val[s];
          end
        end
      end
      OP_RFIND: begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (slot_key[i] != '0 && slot_val[i] == val) begin
            r.status = STS_HIT;
            r.found_key = slot_key[i];
            break;
          end
        end
      end
      default: begin
        for (int i = 0; i < TABLE_SLOTS; i++) slot_key[i] = '0;
        occupied = 0;
        r.status = STS_NEW;
      end
    endcase
    r.entries_used = occupied[ENT_W-1:0];
    return r;
  endfunction

  // compare one field of a result beat
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // watch both channels: check result beats first, then predict accepted beats
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        slot_key[i] = '0;
        slot_val[i] = '0;
      end
      occupied = 0;
      mismatches = 0;
      expected_results.delete();
      mismatch_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no operation outstanding: 0x%0h", m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(want.status), 32'(m_axis_tdata[2:0]));
          check_field("found_value", want.found_value, m_axis_tdata[34:3]);
          check_field("found_key", want.found_key, m_axis_tdata[66:35]);
          check_field("entries_used", 32'(want.entries_used), 32'(m_axis_tdata[75:67]));
          check_field("padding", 32'd0, 32'(m_axis_tdata[79:76]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(apply_op(op_e'(s_axis_tuser), s_axis_tdata[31:0],
                                            s_axis_tdata[63:32]));
      end
      mismatch_count_o <= mismatches;
      pending_o <= expected_results.size();
    end
  end

endmodule

// File: test/tb_linear_probe_hash_table.sv
// testbench top for the linear-probe hash table: stimulus, stalls and verdict
`timescale 1ns / 100ps

module tb_linear_probe_hash_table import lpht_pkg::*; ();

  localparam int unsigned IDLE_LIMIT  = 5000;
  localparam int unsigned TAIL_CYCLES = 300;
  localparam int unsigned ITEM_TARGET = 1950;
  localparam int unsigned MAX_WAIT    = 14;
  localparam int unsigned KEEP_KEYS   = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // key [31:0], value [63:32]
  logic [1:0]  s_axis_tuser = '0;   // opcode [1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;        // status [2:0], found_value [34:3],
                                    // found_key [66:35], entries_used [75:67], zero above

  int unsigned mismatches;
  int unsigned pending;
  int unsigned ops_sent = 0;
  int unsigned idle_cycles = 0;
  bit          send_burst = 1'b0;
  bit          recv_burst = 1'b0;
  logic [31:0] live_keys [$];
  logic [31:0] value_pool [8];

  always #2 clk_i = ~clk_i;

  linear_probe_hash_table i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  linear_probe_hash_table_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stall before each beat, with stall-free stretches
  initial begin
    int unsigned stall;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // send one operation beat after a random gap
  task automatic issue_op(op_e op, logic [31:0] key, logic [31:0] val);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {val, key};
    do @(posedge clk_i); while (!s_axis_tready);
    ops_sent++;
    // remember keys so later beats can hit them
    if (op == OP_CLEAR) begin
      live_keys.delete();
    end else if (op == OP_INSERT && key != '0 && live_keys.size() < KEEP_KEYS) begin
      live_keys.push_back(key);
    end
  endtask

  // hold off the sender until every outstanding result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // key whose home slot sits at the table edges, so probes collide and wrap
  function automatic logic [31:0] colliding_key();
    logic [31:0] k;
    k = $urandom;
    case ($urandom_range(0, 3))
      0: k[7:0] = 8'h00;
      1: k[7:0] = 8'h01;
      2: k[7:0] = 8'hfe;
      default: k[7:0] = 8'hff;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] fresh_key();
    return ($urandom_range(0, 9) < 7) ? 32'($urandom) : colliding_key();
  endfunction

  function automatic logic [31:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45 && live_keys.size() > 0) return live_keys[$urandom_range(0, live_keys.size() - 1)];
    if (r < 65) return colliding_key();
    if (r < 90) return $urandom;
    if (r < 95) return 32'h0;
    case ($urandom_range(0, 3))
      0: return 32'hffff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0001;
      default: return 32'h0000_0100;
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return value_pool[$urandom_range(0, 7)];
    if (r < 43) return 32'h0;
    if (r < 46) return 32'hffff_ffff;
    return $urandom;
  endfunction

  // main stimulus and verdict
  initial begin
    int unsigned n;
    int unsigned r;
    foreach (value_pool[i]) value_pool[i] = $urandom;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, bad key, collisions, wrap-around, scan order, clear
    issue_op(OP_LOOKUP, 32'h0000_0001, 32'h0);
    issue_op(OP_RFIND,  32'h0,         32'h0);
    issue_op(OP_INSERT, 32'h0,         32'h0000_0005);
    issue_op(OP_INSERT, 32'hffff_ffff, 32'hffff_ffff);
    issue_op(OP_INSERT, 32'h0000_01ff, 32'h0);
    issue_op(OP_INSERT, 32'h0000_0100, 32'h1234_5678);
    issue_op(OP_INSERT, 32'h0000_0001, 32'ha5a5_a5a5);
    issue_op(OP_LOOKUP, 32'h0000_0100, 32'h0);
    issue_op(OP_LOOKUP, 32'h0000_0001, 32'h0);
    issue_op(OP_LOOKUP, 32'h0000_01ff, 32'h0);
    issue_op(OP_LOOKUP, 32'h0,         32'h0);
    issue_op(OP_LOOKUP, 32'h0000_0201, 32'h0);
    issue_op(OP_INSERT, 32'h0000_0001, 32'h5a5a_5a5a);
    issue_op(OP_RFIND,  32'h0,         32'h0);
    issue_op(OP_RFIND,  32'h0,         32'h5a5a_5a5a);
    issue_op(OP_RFIND,  32'h0,         32'hdead_beef);
    issue_op(OP_INSERT, 32'h8000_0000, 32'hffff_ffff);
    issue_op(OP_RFIND,  32'h0,         32'hffff_ffff);
    issue_op(OP_CLEAR,  32'h0,         32'h0);
    issue_op(OP_LOOKUP, 32'h0000_0001, 32'h0);
    issue_op(OP_RFIND,  32'h0,         32'h0);
    issue_op(OP_INSERT, 32'h0000_0001, 32'h0000_0007);
    issue_op(OP_LOOKUP, 32'hffff_ffff, 32'h0);
    drain_results();

    // random phases: fills up to the load limit and mixed traffic
    while (ops_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(260, 300);
        for (int i = 0; i < n && ops_sent < ITEM_TARGET; i++) begin
          r = $urandom_range(0, 9);
          if (r < 8) issue_op(OP_INSERT, (r < 7) ? fresh_key() : pick_key(), pick_value());
          else if (r < 9) issue_op(OP_LOOKUP, pick_key(), $urandom);
          else issue_op(OP_RFIND, $urandom, pick_value());
        end
      end else begin
        n = $urandom_range(40, 150);
        for (int i = 0; i < n && ops_sent < ITEM_TARGET; i++) begin
          r = $urandom_range(0, 99);
          if (r < 45) issue_op(OP_INSERT, pick_key(), pick_value());
          else if (r < 75) issue_op(OP_LOOKUP, pick_key(), $urandom);
          else if (r < 97) issue_op(OP_RFIND, $urandom, pick_value());
          else issue_op(OP_CLEAR, $urandom, $urandom);
        end
      end
      if ($urandom_range(0, 1) == 0) drain_results();
      if ($urandom_range(0, 2) == 0) issue_op(OP_CLEAR, $urandom, $urandom);
    end

    // wait for the last results, then let the block settle
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
